### rtl/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

    // Default number of entries held
    parameter int SPQ_CAPACITY = 16;

    // Field widths
    parameter int VALUE_W  = 32;
    parameter int STATUS_W = 2;
    parameter int OCC_W    = 5;

    // Operation codes
    typedef enum logic [0:0] {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // One operation handed to the entry array
    typedef struct packed {
        logic               en;
        t_func              func;
        logic [VALUE_W-1:0] value;
    } t_op;

    // Outcome of one operation
    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] removed;
    } t_res;

endpackage

### rtl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
    logic                         valid;
    logic                         ready;
    spq_pkg::t_func               func;
    logic [spq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::VALUE_W-1:0]  removed_value;
    spq_pkg::t_status             status;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    output ready);
endinterface

### rtl/spq_sort_array.sv
// Sorted register file with parallel compare-and-shift insert and remove.
module spq_sort_array #(
    parameter int  CAPACITY = spq_pkg::SPQ_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_op       i_op,
    output spq_pkg::t_res      o_res,
    output logic [CNT_W-1:0]   o_next_count
);

    logic [spq_pkg::VALUE_W-1:0] r_entry [CAPACITY];
    logic [spq_pkg::VALUE_W-1:0] n_ins   [CAPACITY];
    logic [spq_pkg::VALUE_W-1:0] n_rem   [CAPACITY];
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;

    logic [CAPACITY-1:0] live;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic                is_full;
    logic                is_empty;
    logic                is_dup;
    logic                do_ins;
    logic                do_rem;

    // Per-entry comparators against the incoming value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            live[i] = CNT_W'(i) < r_count;
            lt[i]   = live[i] && ($signed(r_entry[i]) < $signed(i_op.value));
            eq[i]   = live[i] && (r_entry[i] == i_op.value);
        end
    end

    assign is_full  = r_count == CNT_W'(CAPACITY);
    assign is_empty = r_count == '0;
    assign is_dup   = |eq;
    assign do_ins   = i_op.en && i_op.func == spq_pkg::FN_INSERT && !is_dup && !is_full;
    assign do_rem   = i_op.en && i_op.func == spq_pkg::FN_REMOVE && !is_empty;

    // Next value of each entry for insert (open a slot) and remove (shift down)
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign n_ins[g] = lt[g] ? r_entry[g] : i_op.value;
        end else begin : g_rest
            assign n_ins[g] = lt[g]     ? r_entry[g]   :
                              lt[g - 1] ? i_op.value   : r_entry[g - 1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign n_rem[g] = r_entry[g];
        end else begin : g_inner
            assign n_rem[g] = r_entry[g + 1];
        end
    end

    // Status, removed value and count after the operation
    always_comb begin
        n_count       = r_count;
        o_res.removed = '0;
        if (i_op.func == spq_pkg::FN_REMOVE) begin
            priority if (is_empty) begin
                o_res.status = spq_pkg::ST_EMPTY;
            end else begin
                o_res.status  = spq_pkg::ST_OK;
                o_res.removed = r_entry[0];
                n_count       = r_count - 1'b1;
            end
        end else begin
            priority if (is_dup) begin
                o_res.status = spq_pkg::ST_DUP;
            end else if (is_full) begin
                o_res.status = spq_pkg::ST_FULL;
            end else begin
                o_res.status = spq_pkg::ST_OK;
                n_count      = r_count + 1'b1;
            end
        end
    end

    assign o_next_count = n_count;

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (do_ins) begin
                r_entry[i] <= n_ins[i];
            end else if (do_rem) begin
                r_entry[i] <= n_rem[i];
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op.en) begin
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_op.en && i_op.func == spq_pkg::FN_REMOVE && !is_empty)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not drop the count by one");

    a_insert_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && do_ins) |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not raise the count by one");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> $signed(r_entry[0]) < $signed(r_entry[1]))
        else $error("head entries out of order");
`endif

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted minimum-first priority queue.
//
//  channel | dir | payload                              | handshake
//  i_req   | in  | func, value                          | valid/ready
//  o_rsp   | out | removed_value, status, occupancy     | valid/ready
//
// One transaction per cycle sustained while o_rsp.ready stays high; each result passes
// the input register, then compare-and-shift over all entries into the result register.
// Reset clears the fill count and both valid flags; entries need no clearing pass.
// A stalled result holds in the output register while one more request waits in
// the input register; ready drops only when both are full.
module sorted_priority_queue #(
    parameter int  CAPACITY = spq_pkg::SPQ_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    logic                        r_in_valid;
    spq_pkg::t_func              r_func;
    logic [spq_pkg::VALUE_W-1:0] r_value;

    logic                        r_out_valid;
    spq_pkg::t_res               r_res;
    logic [spq_pkg::OCC_W-1:0]   r_occ;

    logic                        out_load;
    logic                        advance;
    spq_pkg::t_op                op;
    spq_pkg::t_res               res;
    logic [CNT_W-1:0]            next_count;

    // Handshake: the result register frees when empty or being taken
    assign out_load    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_load;
    assign i_req.ready = !r_in_valid || out_load;

    assign op.en    = advance;
    assign op.func  = r_func;
    assign op.value = r_value;

    spq_sort_array #(
        .CAPACITY (CAPACITY)
    ) u_array (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .o_res        (res),
        .o_next_count (next_count)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
            r_func     <= i_req.func;
            r_value    <= i_req.value;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_res       <= res;
            r_occ       <= spq_pkg::OCC_W'(next_count);
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_res.removed;
    assign o_rsp.status        = r_res.status;
    assign o_rsp.occupancy     = r_occ;

endmodule

### tb/sv/tb.sv
// Testbench of the sorted minimum-first priority queue: random operations vs a queue tracker.

// Expected outcome of one accepted operation
typedef struct {
    logic [spq_pkg::VALUE_W-1:0] removed;
    spq_pkg::t_status            status;
    logic [spq_pkg::OCC_W-1:0]   occupancy;
} t_outcome;

// Tracks the queue contents and the outcomes still owed by the block
class min_queue_tracker;
    logic signed [spq_pkg::VALUE_W-1:0] held[$];
    t_outcome                           outcomes_due[$];
    int                                 capacity;
    int                                 mismatches;

    function new(int cap);
        capacity   = cap;
        mismatches = 0;
    endfunction

    function int pending();
        return outcomes_due.size();
    endfunction

    function void report(string msg);
        $display("MISMATCH %s", msg);
        mismatches++;
    endfunction

    // Apply one accepted transaction and queue the outcome it must produce
    function void apply_op(spq_pkg::t_func fn, logic [spq_pkg::VALUE_W-1:0] value);
        t_outcome                           res;
        logic signed [spq_pkg::VALUE_W-1:0] sval;
        int                                 pos;
        sval        = value;
        res.removed = '0;
        res.status  = spq_pkg::ST_OK;
        if (fn == spq_pkg::FN_INSERT) begin
            pos = 0;
            while (pos < held.size() && held[pos] < sval)
                pos++;
            if (pos < held.size() && held[pos] == sval)
                res.status = spq_pkg::ST_DUP;
            else if (held.size() >= capacity)
                res.status = spq_pkg::ST_FULL;
            else
                held.insert(pos, sval);
        end else begin
            if (held.size() == 0)
                res.status = spq_pkg::ST_EMPTY;
            else
                res.removed = held.pop_front();
        end
        res.occupancy = spq_pkg::OCC_W'(held.size());
        outcomes_due.push_back(res);
    endfunction

    // Compare one accepted result with the oldest outcome owed
    function void check_result(logic [spq_pkg::VALUE_W-1:0] removed,
                               spq_pkg::t_status status,
                               logic [spq_pkg::OCC_W-1:0] occupancy);
        t_outcome want;
        if (outcomes_due.size() == 0) begin
            report($sformatf("unexpected result removed=%h status=%0d occ=%0d",
                             removed, status, occupancy));
            return;
        end
        want = outcomes_due.pop_front();
        if (removed !== want.removed)
            report($sformatf("removed_value got %h want %h", removed, want.removed));
        if (status !== want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
        if (occupancy !== want.occupancy)
            report($sformatf("occupancy got %0d want %0d", occupancy, want.occupancy));
    endfunction
endclass

module tb;

    localparam int N_RANDOM     = 1700;
    localparam int HOLD_CYCLES  = 64;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    min_queue_tracker tracker = new(spq_pkg::SPQ_CAPACITY);
    int               results_seen = 0;
    int               idle_cycles  = 0;

    // Known values on every input from time zero
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = spq_pkg::FN_INSERT;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Values: small pool for duplicates, extremes, or anything
    function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return spq_pkg::VALUE_W'($urandom_range(0, 24)) - spq_pkg::VALUE_W'(12);
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Offer one transaction after an optional gap; valid stays high on return
    task automatic send_op(input spq_pkg::t_func fn,
                           input logic [spq_pkg::VALUE_W-1:0] value, input int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= fn;
        req_if.value <= value;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        tracker.apply_op(fn, value);
    endtask

    // Result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                tracker.check_result(rsp_if.removed_value, rsp_if.status, rsp_if.occupancy);
                results_seen++;
            end
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stalls plus long hold-offs that back the block up
    initial begin
        int hold_at;
        int stall;
        hold_at = 250;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (results_seen >= hold_at) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_at += 850;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Request side: reset, directed cases, random bursts, drain
    initial begin
        int             sent;
        int             burst_len;
        int             ins_pct;
        bit             no_idle;
        spq_pkg::t_func fn;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Remove on empty, extremes, duplicate, then fill to capacity
        send_op(spq_pkg::FN_REMOVE, $urandom(), pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h7FFF_FFFF, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h8000_0000, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h0000_0000, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'hFFFF_FFFF, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h0000_0001, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h0000_0000, pick_gap());
        send_op(spq_pkg::FN_REMOVE, 32'hFFFF_FFFF, pick_gap());
        for (int k = 0; k < spq_pkg::SPQ_CAPACITY - 4; k++)
            send_op(spq_pkg::FN_INSERT, 32'd100 + k, 0);
        // Full queue: new value dropped, duplicates still flagged as such
        send_op(spq_pkg::FN_INSERT, 32'd200, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'd105, pick_gap());
        send_op(spq_pkg::FN_INSERT, 32'h7FFF_FFFF, pick_gap());

        // Bursts that lean toward filling, churning or draining
        sent = 0;
        while (sent < N_RANDOM) begin
            burst_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0: ins_pct = 85;
                1: ins_pct = 50;
                default: ins_pct = 15;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                fn = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::FN_INSERT
                                                       : spq_pkg::FN_REMOVE;
                send_op(fn, pick_value(), no_idle ? 0 : pick_gap());
                sent++;
            end
        end
        req_if.valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_sort_array.sv
rtl/sorted_priority_queue.sv
tb/sv/tb.sv
